/* sv/rtvs_pkg.sv */
// Package for the raster timing block: payload types and timing constants.
package rtvs_pkg;

    localparam int DOT_W  = 9;
    localparam int LINE_W = 10;
    localparam int CYC_W  = 3;

    localparam int DOTS_PER_LINE_DEF = 341;

    // Raster landmarks
    localparam logic signed [LINE_W-1:0] VBLANK_LINE   = 10'sd241;
    localparam logic signed [LINE_W-1:0] WRAP_LINE     = 10'sd261;
    localparam logic signed [LINE_W-1:0] VISIBLE_LINES = 10'sd240;
    localparam logic signed [LINE_W-1:0] PRERENDER     = -10'sd1;
    localparam logic [DOT_W-1:0]         VISIBLE_DOTS  = 9'd256;

    typedef struct packed {
        logic [CYC_W-1:0] cycles;
        logic [7:0]       sprite_zero_y;
        logic [7:0]       sprite_zero_x;
    } in_item_t;

    typedef struct packed {
        logic signed [LINE_W-1:0] line_now;
        logic [DOT_W-1:0]         dot_now;
        logic                     vblank_status;
        logic                     sprite_zero_status;
        logic                     frame_end;
        logic                     nmi_request;
        logic [31:0]              frame_number;
    } out_item_t;

endpackage

/* sv/raster_timing_vblank_sprite0_hit.sv */
// The result of an accepted request is captured in the output register on the accepting edge.
// Throughput: one request per cycle while in_stall is low; the raster state updates on the accepting edge.
// in_stall rises only while a finished result is held by out_stall.
// Reset (rst_n low, asynchronous): line -1, dot 0, flags and frame count cleared,
// NMI disabled, output empty. Configuration writes are taken in any cycle.
module raster_timing_vblank_sprite0_hit
    import rtvs_pkg::*;
#(
    parameter int DOTS_PER_LINE = DOTS_PER_LINE_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    // configuration write
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic      cfg_data,
    // request channel
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    // result channel
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    localparam logic [DOT_W:0] DOTS_LIM = (DOT_W+1)'(DOTS_PER_LINE);

    // raster state
    logic signed [LINE_W-1:0] line_reg, line_next;
    logic [DOT_W-1:0]         dot_reg, dot_next;
    logic                     vblank_reg, vblank_next;
    logic                     hit_reg, hit_next;
    logic [31:0]              frame_reg, frame_next;
    logic                     nmi_en_reg;

    // output stage
    logic      out_valid_reg;
    out_item_t out_data_reg, out_data_next;

    logic                     accept;
    logic                     started;
    logic [DOT_W:0]           dot_sum;
    logic                     wrap;
    logic signed [LINE_W-1:0] line_inc;
    logic                     line_end;
    logic                     hit_base;
    logic signed [LINE_W:0]   line_ext, dot_ext, y_ext, x_ext;
    logic                     in_window;

    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // step logic
    always_comb
    begin
        // vblank start check on the state before the step
        started    = (line_reg == VBLANK_LINE) && !vblank_reg;
        frame_next = started ? frame_reg + 32'd1 : frame_reg;

        // dot advance, three dots per CPU cycle, wraps at most once
        dot_sum  = {1'b0, dot_reg} + (DOT_W+1)'({in_data.cycles, 1'b0})
                   + (DOT_W+1)'(in_data.cycles);
        wrap     = dot_sum >= DOTS_LIM;
        dot_next = wrap ? DOT_W'(dot_sum - DOTS_LIM) : dot_sum[DOT_W-1:0];

        // line advance and end of frame
        line_inc  = line_reg + 10'sd1;
        line_end  = wrap && (line_inc >= WRAP_LINE);
        line_next = wrap ? (line_end ? PRERENDER : line_inc) : line_reg;

        vblank_next = line_end ? 1'b0 : (started || vblank_reg);
        hit_base    = line_end ? 1'b0 : hit_reg;

        // sprite 0 box against the new raster position
        line_ext  = {line_next[LINE_W-1], line_next};
        dot_ext   = {2'b00, dot_next};
        y_ext     = {3'b000, in_data.sprite_zero_y};
        x_ext     = {3'b000, in_data.sprite_zero_x};
        in_window = !started
                    && (line_next >= 10'sd0) && (line_next < VISIBLE_LINES)
                    && (dot_reg < VISIBLE_DOTS)
                    && !hit_base
                    && (y_ext >= line_ext - 11'sd8) && (y_ext <= line_ext)
                    && (x_ext >= dot_ext - 11'sd8) && (x_ext <= dot_ext);
        hit_next  = hit_base || in_window;

        out_data_next.line_now           = line_next;
        out_data_next.dot_now            = dot_next;
        out_data_next.vblank_status      = vblank_next;
        out_data_next.sprite_zero_status = hit_next;
        out_data_next.frame_end          = started;
        out_data_next.nmi_request        = started && nmi_en_reg;
        out_data_next.frame_number       = frame_next;
    end

    // control and raster state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg      <= PRERENDER;
            dot_reg       <= '0;
            vblank_reg    <= 1'b0;
            hit_reg       <= 1'b0;
            frame_reg     <= '0;
            nmi_en_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                nmi_en_reg <= cfg_data;
            end
            if (accept)
            begin
                line_reg   <= line_next;
                dot_reg    <= dot_next;
                vblank_reg <= vblank_next;
                hit_reg    <= hit_next;
                frame_reg  <= frame_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

/* sv/rtvs_checker.sv */
// Port-level checker for the raster timing block, with its bind.
module rtvs_checker
    import rtvs_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_data
);

    // a stalled result stays
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_data))
        else $error("stalled result changed");

    // every accepted request shows a result on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("accepted request produced no result");

    // NMI only with a vblank start, which lands on line 241 or 242 with vblank set
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.nmi_request |-> out_data.frame_end)
        else $error("NMI without vblank start");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.frame_end |->
            out_data.vblank_status
            && (out_data.line_now == 10'sd241 || out_data.line_now == 10'sd242))
        else $error("vblank start at wrong raster position");

endmodule

bind raster_timing_vblank_sprite0_hit rtvs_checker u_rtvs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
